// ===== rtl/sks_pkg.sv =====
// shared types, constants and controller codes of the string key selection sort
`default_nettype none

package sks_pkg;

    localparam int SKS_MAX_KEYS  = 16;
    localparam int SKS_KEY_BYTES = 8;
    localparam int SKS_FIELD_W   = 64;

    typedef logic [SKS_FIELD_W-1:0] t_sks_field;

    typedef struct packed {
        t_sks_field key;
        logic       last_item;
    } t_sks_in;

    typedef struct packed {
        t_sks_field sorted_key;
        logic       last_out;
        logic       overflow;
    } t_sks_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SWAP_FAR,
        S_SWAP_NEAR
    } t_sks_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start_sort;
        logic rd_en;
        logic swap_far;
        logic swap_near;
        logic finish;
    } t_sks_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic pos_end;
    } t_sks_status;

endpackage

`default_nettype wire

// ===== rtl/string_key_selection_sort.sv =====
// top level of the string key selection sort: controller plus datapath
//
// usage:
//   load a list of keys, one transaction per key: an item is taken at a rising
//   edge with start high and busy low. key carries the packed string (first
//   character in the top byte, zero padded); only the low KEY_BYTES bytes are
//   kept. last_item closes the list and starts the sort, busy then stays high
//   until the run is done. keys beyond MAX_KEYS are dropped and reported
//   through overflow on every result of that run.
//   results come out in ascending order, each for one cycle with
//   o_result_valid high; last_out marks the final key. the receiver cannot
//   stall, so results are not held.
// timing:
//   with n keys stored, the pass for position p reads the unsorted part of the
//   store from p on (one store read and one compare per cycle), then swaps
//   over the single write port, far half first and near half second; one
//   result appears at the end of each pass.
// reset: synchronous, clears the key count, the overflow flag and the control
//   state; the key store contents are left as they are.
`default_nettype none

module string_key_selection_sort
    import sks_pkg::*;
#(
    parameter int MAX_KEYS  = SKS_MAX_KEYS,
    parameter int KEY_BYTES = SKS_KEY_BYTES
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    output logic     busy,
    input  t_sks_in  i_item,
    output logic     o_result_valid,
    output t_sks_out o_result
);

    t_sks_cmd    w_cmd;
    t_sks_status w_status;

    sks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_item (i_item.last_item),
        .i_status    (w_status),
        .o_busy      (busy),
        .o_cmd       (w_cmd)
    );

    sks_datapath #(
        .MAX_KEYS  (MAX_KEYS),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_key          (i_item.key),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/sks_ctrl.sv =====
// controller state machine of the string key selection sort
`default_nettype none

module sks_ctrl
    import sks_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_last_item,
    input  t_sks_status i_status,
    output logic        o_busy,
    output t_sks_cmd    o_cmd
);

    t_sks_state r_state;
    t_sks_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_last_item) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SWAP_FAR;
            end
            S_SWAP_FAR: begin
                n_state = S_SWAP_NEAR;
            end
            S_SWAP_NEAR: begin
                n_state = i_status.pos_end ? S_IDLE : S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy = 1'b1;
        o_cmd  = '0;
        case (r_state)
            S_IDLE: begin
                o_busy           = 1'b0;
                o_cmd.load       = i_start;
                o_cmd.start_sort = i_start && i_last_item;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_SWAP_FAR: begin
                o_cmd.swap_far = 1'b1;
            end
            S_SWAP_NEAR: begin
                o_cmd.swap_near = 1'b1;
                o_cmd.finish    = i_status.pos_end;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sks_datapath.sv =====
// key store, scan counters, minimum tracking and result register of the sort
`default_nettype none

module sks_datapath
    import sks_pkg::*;
#(
    parameter int MAX_KEYS  = SKS_MAX_KEYS,
    parameter int KEY_BYTES = SKS_KEY_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_sks_cmd    i_cmd,
    input  t_sks_field  i_key,
    output t_sks_status o_status,
    output logic        o_result_valid,
    output t_sks_out    o_result
);

    localparam int KEY_W = KEY_BYTES * 8;
    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    logic [KEY_W-1:0] r_mem [MAX_KEYS];

    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_scan;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic [KEY_W-1:0] r_rd_data;
    logic [KEY_W-1:0] r_best_key;
    logic [IDX_W-1:0] r_best_idx;
    logic [KEY_W-1:0] r_pos_key;
    logic             r_out_valid;
    t_sks_out         r_out;

    logic             w_full;
    logic [CNT_W-1:0] w_count_m1;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [KEY_W-1:0] w_wr_data;
    logic             w_take;

    assign w_full     = (r_count == CNT_W'(MAX_KEYS));
    assign w_count_m1 = r_count - 1'b1;
    assign w_last_idx = w_count_m1[IDX_W-1:0];

    assign o_status.scan_end = (r_scan == w_last_idx);
    assign o_status.pos_end  = (r_pos == w_last_idx);

    // single write port shared by loading and the two halves of a swap
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[IDX_W-1:0];
        w_wr_data = i_key[KEY_W-1:0];
        if (i_cmd.load && !w_full) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.swap_far) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_best_idx;
            w_wr_data = r_pos_key;
        end else if (i_cmd.swap_near) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pos;
            w_wr_data = r_best_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_scan];
        r_rd_idx  <= r_scan;
    end

    // first key of a pass seeds the minimum, strict compare keeps the earliest
    assign w_take = r_rd_valid && ((r_rd_idx == r_pos) || (r_rd_data < r_best_key));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_key <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (r_rd_valid && (r_rd_idx == r_pos)) begin
            r_pos_key <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_pos      <= '0;
            r_scan     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            if (i_cmd.load) begin
                if (w_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.start_sort) begin
                r_pos  <= '0;
                r_scan <= '0;
            end else if (i_cmd.rd_en) begin
                r_scan <= r_scan + 1'b1;
            end else if (i_cmd.swap_near) begin
                r_pos  <= r_pos + 1'b1;
                r_scan <= r_pos + 1'b1;
            end
            if (i_cmd.finish) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.swap_far;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.swap_far) begin
            r_out.sorted_key <= t_sks_field'(r_best_key);
            r_out.last_out   <= o_status.pos_end;
            r_out.overflow   <= r_dropped;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count beyond capacity");

    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_scan >= r_pos) && (CNT_W'(r_scan) < r_count))
        else $error("scan read outside the unsorted part of the store");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobes in consecutive cycles");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_out) |=> (r_count == '0) && !r_dropped)
        else $error("store not cleared after the final result");
`endif

endmodule

`default_nettype wire
